// File: rtl/core/glc_pkg.sv
// Shared types and constants of the grid line-of-sight checker.
package glc_pkg;

  localparam int MAX_CELLS_DEF = 65536;
  localparam int MAX_SIDE_DEF  = 256;
  localparam int SIDE_MIN      = 3;

  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CELL_IDX_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] GRID_SIDE_RESET = 9'd256;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [CELL_IDX_W-1:0] from_cell;
    logic [CELL_IDX_W-1:0] to_cell;
    logic                  occupied_bit;
  } in_t;

  typedef struct packed {
    logic line_free;
    logic index_error;
  } out_t;

  // Handshake status (busy and done) of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: rtl/core/glc_div.sv
// Bit-serial restoring divider that splits a cell index into row and column.
module glc_div import glc_pkg::*; #(
  parameter int DW = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [CELL_IDX_W-1:0] dividend,
  input  logic [DW-1:0]         divisor,
  output div_status_t           status,
  output logic [CELL_IDX_W-1:0] quotient,
  output logic [DW-1:0]         remainder
);

  localparam int CNT_W = $clog2(CELL_IDX_W + 1);

  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;
  logic [CELL_IDX_W-1:0] quo;
  logic [DW-1:0]         rem;
  logic [DW:0]           trial;
  logic                  fits;

  always_comb begin
    trial = {rem, quo[CELL_IDX_W-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        quo <= {quo[CELL_IDX_W-2:0], fits};
        if (fits) begin
          rem <= DW'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[DW-1:0];
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        quo  <= dividend;
        rem  <= '0;
        cnt  <= CNT_W'(CELL_IDX_W);
        busy <= 1'b1;
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;
  assign remainder   = rem;

endmodule

// File: rtl/core/glc_grid.sv
// One-bit occupancy memory with a clearing sweep after reset.
module glc_grid #(
  parameter int MAX_CELLS = 65536,
  parameter int AW        = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  output logic          busy
);

  logic          mem [MAX_CELLS];
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(MAX_CELLS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign busy = clearing;

endmodule

// File: rtl/core/grid_line_of_sight_check_core.sv
// Top level of the grid line-of-sight checker: sequencer and line walker.
//
// Input words arrive on in_valid/in_ready with an in_t payload; each word
// gives exactly one result word on out_valid/out_ready. A write word sets one
// occupancy cell; a query word walks the line between two cells.
// Grid width and height are set through cfg_wr_en/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Out-of-range values are saturated to 3..MAX_SIDE. A write, or
// a query with an index outside the grid, goes from the index check straight
// to the result. Any other query sends each index through the shared serial
// divider at one quotient bit per cycle; the walk then reads one cell per
// cycle from the memory read port, at most as many as the longer grid side.
// One word is in work at a time; in_ready is high only when idle.
// After reset the occupancy memory is swept clear, one cell per cycle;
// in_ready stays low meanwhile, configuration is taken.
// The result sits in an output register; while the receiver stalls the
// next word can still be accepted and worked, and its result waits until the
// register is free.
module grid_line_of_sight_check_core import glc_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  parameter int MAX_SIDE  = MAX_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW    = $clog2(MAX_CELLS);
  localparam int SDW   = $clog2(MAX_SIDE + 1);
  localparam int XW    = $clog2(MAX_SIDE);
  localparam int CW    = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int EW    = XW + 3;
  localparam int AREAW = 2 * SDW;

  typedef enum logic [2:0] {
    IDLE, AREA, CHECK, DIV_FROM, DIV_TO, SETUP, WALK, FINISH
  } state_t;

  state_t           state;
  in_t              item;
  out_t             res;
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic [SDW-1:0]   w_use;
  logic [SDW-1:0]   h_use;
  logic [AREAW-1:0] area;
  logic             from_inside;
  logic             to_inside;

  logic [XW-1:0]    x;
  logic [XW-1:0]    y;
  logic [XW-1:0]    x1;
  logic [XW-1:0]    y1;
  logic [XW-1:0]    dxu;
  logic [XW-1:0]    dyu;
  logic signed [EW-1:0] dx;
  logic signed [EW-1:0] dy;
  logic signed [EW-1:0] err;
  logic signed [EW-1:0] e2;
  logic signed [EW-1:0] err_next;
  logic             xstep;
  logic             ystep;
  logic             sx_neg;
  logic             sy_neg;
  logic [CW-1:0]    walk_pos;
  logic [CW-1:0]    walk_pos_next;
  logic [CW-1:0]    step_x;
  logic [CW-1:0]    step_y;
  logic             prev_valid;
  logic             prev_last;
  logic             prev_oob;

  logic [31:0]      from_wide;
  logic [31:0]      walk_pos_wide;

  logic                  div_start;
  logic [CELL_IDX_W-1:0] div_dividend;
  div_status_t           div_status;
  logic [CELL_IDX_W-1:0] div_quo;
  logic [SDW-1:0]        div_rem;

  logic             grid_wr_en;
  logic [AW-1:0]    grid_wr_addr;
  logic [AW-1:0]    grid_rd_addr;
  logic             grid_rd_data;
  logic             grid_busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_SIDE_RESET;
      grid_height <= GRID_SIDE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(grid_width) < 32'(SIDE_MIN)) begin
      w_use = SDW'(SIDE_MIN);
    end else if (32'(grid_width) > 32'(MAX_SIDE)) begin
      w_use = SDW'(MAX_SIDE);
    end else begin
      w_use = SDW'(grid_width);
    end
    if (32'(grid_height) < 32'(SIDE_MIN)) begin
      h_use = SDW'(SIDE_MIN);
    end else if (32'(grid_height) > 32'(MAX_SIDE)) begin
      h_use = SDW'(MAX_SIDE);
    end else begin
      h_use = SDW'(grid_height);
    end
  end

  always_comb begin
    from_inside   = (32'(item.from_cell) < 32'(area)) &&
                    (32'(item.from_cell) < 32'(MAX_CELLS));
    to_inside     = (32'(item.to_cell) < 32'(area)) &&
                    (32'(item.to_cell) < 32'(MAX_CELLS));
    from_wide     = 32'(item.from_cell);
    walk_pos_wide = 32'(walk_pos);
  end

  // Divider control: the start index first, then the end index.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = item.from_cell;
    if (state == CHECK) begin
      div_start = (item.operation == OP_QUERY) && from_inside && to_inside;
    end else if (state == DIV_FROM) begin
      div_start    = div_status.done;
      div_dividend = item.to_cell;
    end
  end

  // One Bresenham step from the current cell.
  always_comb begin
    e2            = err <<< 1;
    xstep         = e2 >= dy;
    ystep         = e2 <= dx;
    err_next      = err + (xstep ? dy : EW'(0)) + (ystep ? dx : EW'(0));
    step_x        = sx_neg ? ~CW'(0) : CW'(1);
    step_y        = sy_neg ? (~CW'(w_use) + CW'(1)) : CW'(w_use);
    walk_pos_next = walk_pos + (xstep ? step_x : CW'(0)) + (ystep ? step_y : CW'(0));
    dxu           = (x1 >= x) ? (x1 - x) : (x - x1);
    dyu           = (y1 >= y) ? (y1 - y) : (y - y1);
  end

  assign grid_wr_en   = (state == CHECK) && (item.operation == OP_WRITE) && from_inside;
  assign grid_wr_addr = from_wide[AW-1:0];
  assign grid_rd_addr = walk_pos_wide[AW-1:0];
  assign in_ready     = (state == IDLE) && !grid_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // FINISH refills the output register itself when the old word leaves.
      if (out_valid && out_ready && (state != FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            item  <= in_data;
            state <= AREA;
          end
        end
        AREA: begin
          area  <= AREAW'(w_use) * AREAW'(h_use);
          state <= CHECK;
        end
        CHECK: begin
          res.line_free <= 1'b0;
          if (item.operation == OP_WRITE) begin
            res.index_error <= !from_inside;
            state           <= FINISH;
          end else if (!from_inside || !to_inside) begin
            res.index_error <= 1'b1;
            state           <= FINISH;
          end else begin
            res.index_error <= 1'b0;
            state           <= DIV_FROM;
          end
        end
        DIV_FROM: begin
          if (div_status.done) begin
            x     <= div_rem[XW-1:0];
            y     <= div_quo[XW-1:0];
            state <= DIV_TO;
          end
        end
        DIV_TO: begin
          if (div_status.done) begin
            x1    <= div_rem[XW-1:0];
            y1    <= div_quo[XW-1:0];
            state <= SETUP;
          end
        end
        SETUP: begin
          dx         <= $signed({3'b000, dxu});
          dy         <= -$signed({3'b000, dyu});
          err        <= $signed({3'b000, dxu}) - $signed({3'b000, dyu});
          sx_neg     <= !(x < x1);
          sy_neg     <= !(y < y1);
          walk_pos   <= from_wide[CW-1:0];
          prev_valid <= 1'b0;
          state      <= WALK;
        end
        WALK: begin
          // The memory answers for the cell issued in the previous cycle.
          if (prev_valid && (grid_rd_data || prev_oob)) begin
            res.line_free <= 1'b0;
            state         <= FINISH;
          end else if (prev_valid && prev_last) begin
            res.line_free <= 1'b1;
            state         <= FINISH;
          end else begin
            prev_valid <= 1'b1;
            prev_last  <= (x == x1) && (y == y1);
            prev_oob   <= walk_pos_wide >= 32'(MAX_CELLS);
            err        <= err_next;
            walk_pos   <= walk_pos_next;
            if (xstep) begin
              x <= sx_neg ? (x - XW'(1)) : (x + XW'(1));
            end
            if (ystep) begin
              y <= sy_neg ? (y - XW'(1)) : (y + XW'(1));
            end
          end
        end
        FINISH: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  glc_div #(
    .DW (SDW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (w_use),
    .status    (div_status),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  glc_grid #(
    .MAX_CELLS (MAX_CELLS),
    .AW        (AW)
  ) u_grid (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (grid_wr_en),
    .wr_addr (grid_wr_addr),
    .wr_data (item.occupied_bit),
    .rd_addr (grid_rd_addr),
    .rd_data (grid_rd_data),
    .busy    (grid_busy)
  );

`ifndef ASSERT_OFF
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy)
    else $error("divider started while still busy");

  a_write_not_clearing: assert property (@(posedge clk) disable iff (rst)
    grid_wr_en |-> !grid_busy)
    else $error("grid write during clearing sweep");

  a_error_not_free: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.line_free && out_data.index_error))
    else $error("result word is both free and in error");

  a_write_never_free: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH) && (item.operation == OP_WRITE) |-> !res.line_free)
    else $error("write word reports a free line");

  a_no_accept_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_ready)
    else $error("input accepted before the clearing sweep");
`endif

endmodule
